// ----- rtl/ppc_pkg.sv -----
// Package for planar pose compounding: payload structs, fixed-point formats,
// angle constants and the arctangent table. Used by every module of the block.
`default_nettype none

package ppc_pkg;

  localparam int FRACTION_BITS   = 16;
  localparam int ROTATION_STAGES = 16;
  localparam int MAX_STAGES      = 30;
  localparam int CORDIC_STAGES   =
      (ROTATION_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATION_STAGES;

  // input register, four reduction stages, rotation stages plus sign stage,
  // product stage and rounding stage
  localparam int PIPE_STAGES = CORDIC_STAGES + 8;

  localparam int ANG_SHIFT   = 30 - FRACTION_BITS;
  localparam int RECIP_SHIFT = 32 + FRACTION_BITS;
  localparam int Q_W         = 32 - FRACTION_BITS;
  localparam int QM_W        = Q_W + 34;
  localparam int REM_W       = 36;
  localparam int ANGLE_W     = 32;
  localparam int TRIG_W      = 33;
  localparam int Z_W         = 33;
  localparam int PROD_W      = 32 + TRIG_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int RND_W       = SUM_W - 30;
  localparam int ACC_W       = RND_W + 1;

  localparam logic OP_TRANSPOSED = 1'b0;
  localparam logic OP_STANDARD   = 1'b1;

  localparam logic [32:0] ANG_TWO_PI        = 33'd6746518852;
  localparam logic [32:0] ANG_PI            = 33'd3373259426;
  localparam logic [32:0] ANG_HALF_PI       = 33'd1686629713;
  localparam logic [32:0] ANG_THREE_HALF_PI = 33'd5059889139;
  localparam logic [29:0] CORDIC_GAIN       = 30'd652032874;

  localparam logic [63:0]             RECIP_WIDE =
      64'h4000_0000_0000_0000 / {31'd0, ANG_TWO_PI};
  localparam logic signed [30:0]      RECIP_MUL  = {1'b0, RECIP_WIDE[29:0]};
  localparam logic signed [33:0]      TWO_PI_MUL = {1'b0, ANG_TWO_PI};
  localparam logic signed [REM_W-1:0] TWO_PI_REM = REM_W'(ANG_TWO_PI);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << 29);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_heading;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic signed [31:0] step_heading;
  } ppc_in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_heading;
    logic               saturated;
  } ppc_out_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      5'd24:   v = 32'h0000003F;
      5'd25:   v = 32'h0000001F;
      5'd26:   v = 32'h0000000F;
      5'd27:   v = 32'h00000008;
      5'd28:   v = 32'h00000004;
      5'd29:   v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ppc_angle_reduce.sv -----
// Heading reduction: modulo 2*pi by reciprocal multiply with correction, then
// fold to [-pi/2, pi/2] with a sign flag. Depends on ppc_pkg.
`default_nettype none

module ppc_angle_reduce (
  input  logic                                clk_i,
  input  logic [3:0]                          en_i,
  input  ppc_pkg::ppc_in_t                    data_i,
  output logic signed [ppc_pkg::ANGLE_W-1:0]  angle_o,
  output logic                                neg_o,
  output ppc_pkg::ppc_in_t                    data_o
);

  logic signed [62:0]                  hprod;
  logic signed [ppc_pkg::Q_W-1:0]      quo_d, quo_q;
  ppc_pkg::ppc_in_t                    pl1_q, pl2_q, pl3_q, pl4_q;

  logic signed [ppc_pkg::REM_W-1:0]    head_ext, head_sh, rem_d, rem_q;
  logic signed [ppc_pkg::QM_W-1:0]     qm;

  logic [32:0]                         r0_d, r0_q;

  logic [32:0]                         sub;
  logic signed [33:0]                  diff;
  logic signed [ppc_pkg::ANGLE_W-1:0]  angle_d, angle_q;
  logic                                neg_d, neg_q;

  assign hprod = data_i.pose_heading * ppc_pkg::RECIP_MUL;
  assign quo_d = ppc_pkg::Q_W'(hprod >>> ppc_pkg::RECIP_SHIFT);

  assign head_ext = ppc_pkg::REM_W'(pl1_q.pose_heading);
  assign head_sh  = head_ext <<< ppc_pkg::ANG_SHIFT;
  assign qm       = quo_q * ppc_pkg::TWO_PI_MUL;
  assign rem_d    = head_sh - $signed(qm[ppc_pkg::REM_W-1:0]);

  always_comb begin
    if (rem_q[ppc_pkg::REM_W-1]) begin
      r0_d = 33'(rem_q + ppc_pkg::TWO_PI_REM);
    end else if (rem_q >= ppc_pkg::TWO_PI_REM) begin
      r0_d = 33'(rem_q - ppc_pkg::TWO_PI_REM);
    end else begin
      r0_d = 33'(rem_q);
    end
  end

  always_comb begin
    if (r0_q <= ppc_pkg::ANG_HALF_PI) begin
      sub   = 33'd0;
      neg_d = 1'b0;
    end else if (r0_q < ppc_pkg::ANG_THREE_HALF_PI) begin
      sub   = ppc_pkg::ANG_PI;
      neg_d = 1'b1;
    end else begin
      sub   = ppc_pkg::ANG_TWO_PI;
      neg_d = 1'b0;
    end
    diff    = $signed({1'b0, r0_q}) - $signed({1'b0, sub});
    angle_d = diff[ppc_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      quo_q <= quo_d;
      pl1_q <= data_i;
    end
    if (en_i[1]) begin
      rem_q <= rem_d;
      pl2_q <= pl1_q;
    end
    if (en_i[2]) begin
      r0_q  <= r0_d;
      pl3_q <= pl2_q;
    end
    if (en_i[3]) begin
      angle_q <= angle_d;
      neg_q   <= neg_d;
      pl4_q   <= pl3_q;
    end
  end

  assign angle_o = angle_q;
  assign neg_o   = neg_q;
  assign data_o  = pl4_q;

endmodule

`default_nettype wire

// ----- rtl/ppc_cordic.sv -----
// Pipelined rotation-mode CORDIC, one register stage per iteration, plus a
// final stage that applies the quadrant sign. Depends on ppc_pkg.
`default_nettype none

module ppc_cordic (
  input  logic                                clk_i,
  input  logic [ppc_pkg::CORDIC_STAGES:0]     en_i,
  input  logic signed [ppc_pkg::ANGLE_W-1:0]  angle_i,
  input  logic                                neg_i,
  input  ppc_pkg::ppc_in_t                    data_i,
  output logic signed [ppc_pkg::TRIG_W-1:0]   cos_o,
  output logic signed [ppc_pkg::TRIG_W-1:0]   sin_o,
  output ppc_pkg::ppc_in_t                    data_o
);

  logic signed [ppc_pkg::TRIG_W-1:0] x_q [ppc_pkg::CORDIC_STAGES];
  logic signed [ppc_pkg::TRIG_W-1:0] y_q [ppc_pkg::CORDIC_STAGES];
  logic signed [ppc_pkg::Z_W-1:0]    z_q [ppc_pkg::CORDIC_STAGES];
  logic                              neg_q [ppc_pkg::CORDIC_STAGES];
  ppc_pkg::ppc_in_t                  pl_q [ppc_pkg::CORDIC_STAGES];

  logic signed [ppc_pkg::TRIG_W-1:0] cos_q, sin_q;
  ppc_pkg::ppc_in_t                  out_pl_q;

  for (genvar i = 0; i < ppc_pkg::CORDIC_STAGES; i++) begin : g_stage
    logic signed [ppc_pkg::TRIG_W-1:0] x_p, y_p, x_d, y_d;
    logic signed [ppc_pkg::Z_W-1:0]    z_p, z_d, atan_s;
    logic                              neg_p;
    ppc_pkg::ppc_in_t                  pl_p;

    if (i == 0) begin : g_head
      assign x_p   = $signed(ppc_pkg::TRIG_W'(ppc_pkg::CORDIC_GAIN));
      assign y_p   = '0;
      assign z_p   = ppc_pkg::Z_W'(angle_i);
      assign neg_p = neg_i;
      assign pl_p  = data_i;
    end else begin : g_tail
      assign x_p   = x_q[i-1];
      assign y_p   = y_q[i-1];
      assign z_p   = z_q[i-1];
      assign neg_p = neg_q[i-1];
      assign pl_p  = pl_q[i-1];
    end

    assign atan_s = $signed(ppc_pkg::Z_W'(ppc_pkg::atan_q30(5'(i))));

    always_comb begin
      if (!z_p[ppc_pkg::Z_W-1]) begin
        x_d = x_p - (y_p >>> i);
        y_d = y_p + (x_p >>> i);
        z_d = z_p - atan_s;
      end else begin
        x_d = x_p + (y_p >>> i);
        y_d = y_p - (x_p >>> i);
        z_d = z_p + atan_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        x_q[i]   <= x_d;
        y_q[i]   <= y_d;
        z_q[i]   <= z_d;
        neg_q[i] <= neg_p;
        pl_q[i]  <= pl_p;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ppc_pkg::CORDIC_STAGES]) begin
      cos_q    <= neg_q[ppc_pkg::CORDIC_STAGES-1] ? -x_q[ppc_pkg::CORDIC_STAGES-1]
                                                  :  x_q[ppc_pkg::CORDIC_STAGES-1];
      sin_q    <= neg_q[ppc_pkg::CORDIC_STAGES-1] ? -y_q[ppc_pkg::CORDIC_STAGES-1]
                                                  :  y_q[ppc_pkg::CORDIC_STAGES-1];
      out_pl_q <= pl_q[ppc_pkg::CORDIC_STAGES-1];
    end
  end

  assign cos_o  = cos_q;
  assign sin_o  = sin_q;
  assign data_o = out_pl_q;

endmodule

`default_nettype wire

// ----- rtl/ppc_rotate.sv -----
// Rotates the step by the heading: four products, opcode-selected sums with
// round half up, then saturating adds into the result register. Depends on ppc_pkg.
`default_nettype none

module ppc_rotate (
  input  logic                               clk_i,
  input  logic [1:0]                         en_i,
  input  logic                               out_en_i,
  input  logic signed [ppc_pkg::TRIG_W-1:0]  cos_i,
  input  logic signed [ppc_pkg::TRIG_W-1:0]  sin_i,
  input  ppc_pkg::ppc_in_t                   data_i,
  output ppc_pkg::ppc_out_t                  out_o
);

  function automatic logic [32:0] clamp32(input logic signed [ppc_pkg::ACC_W-1:0] v);
    logic [32:0] r;
    if (v > ppc_pkg::SAT_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < ppc_pkg::SAT_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  logic signed [ppc_pkg::PROD_W-1:0] xc_d, ys_d, yc_d, xs_d;
  logic signed [ppc_pkg::PROD_W-1:0] xc_q, ys_q, yc_q, xs_q;
  logic                              op1_q;
  logic signed [31:0]                px1_q, py1_q, ph1_q, sh1_q;

  logic signed [ppc_pkg::SUM_W-1:0]  tx, ty;
  logic signed [ppc_pkg::RND_W-1:0]  rx_d, ry_d, rx_q, ry_q;
  logic signed [32:0]                hs_d, hs_q;
  logic signed [31:0]                px2_q, py2_q;

  logic signed [ppc_pkg::ACC_W-1:0]  ax, ay;
  logic [32:0]                       cx, cy, ch;
  ppc_pkg::ppc_out_t                 out_d, out_q;

  assign xc_d = data_i.step_x * cos_i;
  assign ys_d = data_i.step_y * sin_i;
  assign yc_d = data_i.step_y * cos_i;
  assign xs_d = data_i.step_x * sin_i;

  always_comb begin
    if (op1_q == ppc_pkg::OP_STANDARD) begin
      tx = ppc_pkg::SUM_W'(xc_q) - ppc_pkg::SUM_W'(ys_q);
      ty = ppc_pkg::SUM_W'(xs_q) + ppc_pkg::SUM_W'(yc_q);
    end else begin
      tx = ppc_pkg::SUM_W'(xc_q) + ppc_pkg::SUM_W'(ys_q);
      ty = ppc_pkg::SUM_W'(yc_q) - ppc_pkg::SUM_W'(xs_q);
    end
    rx_d = ppc_pkg::RND_W'((tx + ppc_pkg::ROUND_HALF) >>> 30);
    ry_d = ppc_pkg::RND_W'((ty + ppc_pkg::ROUND_HALF) >>> 30);
    hs_d = 33'(ph1_q) + 33'(sh1_q);
  end

  always_comb begin
    ax = ppc_pkg::ACC_W'(px2_q) + ppc_pkg::ACC_W'(rx_q);
    ay = ppc_pkg::ACC_W'(py2_q) + ppc_pkg::ACC_W'(ry_q);
    cx = clamp32(ax);
    cy = clamp32(ay);
    ch = clamp32(ppc_pkg::ACC_W'(hs_q));
    out_d.new_x       = cx[31:0];
    out_d.new_y       = cy[31:0];
    out_d.new_heading = ch[31:0];
    out_d.saturated   = cx[32] | cy[32] | ch[32];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xc_q  <= xc_d;
      ys_q  <= ys_d;
      yc_q  <= yc_d;
      xs_q  <= xs_d;
      op1_q <= data_i.opcode;
      px1_q <= data_i.pose_x;
      py1_q <= data_i.pose_y;
      ph1_q <= data_i.pose_heading;
      sh1_q <= data_i.step_heading;
    end
    if (en_i[1]) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      hs_q  <= hs_d;
      px2_q <= px1_q;
      py2_q <= py1_q;
    end
    if (out_en_i) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ----- rtl/planar_pose_compounding.sv -----
// Planar pose compounding: composes a Q16.16 pose (x, y, heading) with a step,
// rotating the step translation by the pose heading and adding the headings,
// with saturation. One transfer is accepted every cycle while in_stall_o is low;
// a result passes through the input register, four angle reduction stages,
// one register per CORDIC iteration, the quadrant sign stage, the product and
// rounding stages and the result register. Each stage holds only while the
// stage after it is full and stalled, so bubbles close up.
// Depends on ppc_pkg, ppc_angle_reduce, ppc_cordic and ppc_rotate.
`default_nettype none

module planar_pose_compounding (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ppc_pkg::ppc_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ppc_pkg::ppc_out_t  out_data_o
);

  logic [ppc_pkg::PIPE_STAGES-1:0] vld_d, vld_q, vld_up, rdy;
  logic                            out_vld_d, out_vld_q, rdy_out;

  ppc_pkg::ppc_in_t                in_q, red_data, cor_data;
  logic signed [ppc_pkg::ANGLE_W-1:0] red_angle;
  logic                            red_neg;
  logic signed [ppc_pkg::TRIG_W-1:0]  cos_v, sin_v;

  assign rdy_out = !out_vld_q || !out_stall_i;

  for (genvar k = 0; k < ppc_pkg::PIPE_STAGES; k++) begin : g_rdy
    assign rdy[k] = rdy_out | ~(&vld_q[ppc_pkg::PIPE_STAGES-1:k]);
  end

  assign vld_up    = {vld_q[ppc_pkg::PIPE_STAGES-2:0], in_valid_i};
  assign vld_d     = (rdy & vld_up) | (~rdy & vld_q);
  assign out_vld_d = rdy_out ? vld_q[ppc_pkg::PIPE_STAGES-1] : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      in_q <= in_data_i;
    end
  end

  ppc_angle_reduce u_reduce (
    .clk_i   (clk_i),
    .en_i    (rdy[4:1]),
    .data_i  (in_q),
    .angle_o (red_angle),
    .neg_o   (red_neg),
    .data_o  (red_data)
  );

  ppc_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (rdy[ppc_pkg::CORDIC_STAGES+5:5]),
    .angle_i (red_angle),
    .neg_i   (red_neg),
    .data_i  (red_data),
    .cos_o   (cos_v),
    .sin_o   (sin_v),
    .data_o  (cor_data)
  );

  ppc_rotate u_rotate (
    .clk_i    (clk_i),
    .en_i     (rdy[ppc_pkg::PIPE_STAGES-1:ppc_pkg::PIPE_STAGES-2]),
    .out_en_i (rdy_out),
    .cos_i    (cos_v),
    .sin_i    (sin_v),
    .data_i   (cor_data),
    .out_o    (out_data_o)
  );

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = out_vld_q;

endmodule

`default_nettype wire

// ----- verif/ppc_pose_checker.sv -----
// Checker for planar_pose_compounding: predicts each composed pose from the
// accepted input transfers and compares the output transfers in order.
// Depends on ppc_pkg for the payload types and the fixed-point constants.
`timescale 1ns / 1ps

module ppc_pose_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  ppc_pkg::ppc_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  ppc_pkg::ppc_out_t out_data_i,
  output int                pending_poses_o,
  output int                mismatches_o
);
  import ppc_pkg::*;

  localparam longint ANGLE_PI      = 64'sd3373259426;
  localparam longint ANGLE_HALF_PI = 64'sd1686629713;
  localparam longint ANGLE_TWO_PI  = 64'sd6746518852;
  localparam longint START_GAIN    = 64'sd652032874;
  localparam longint POS_MAX       = 64'sd2147483647;
  localparam longint POS_MIN       = -64'sd2147483648;

  localparam longint ARCTAN_Q30 [0:29] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  ppc_out_t expected_poses[$];
  ppc_out_t oldest_pose;
  int       mismatch_cnt = 0;

  assign pending_poses_o = expected_poses.size();
  assign mismatches_o    = mismatch_cnt;

  function automatic logic [32:0] clamp_coord(input longint v);
    if (v > POS_MAX) return {1'b1, 32'h7FFF_FFFF};
    if (v < POS_MIN) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic ppc_out_t compose_pose(input ppc_in_t t);
    longint     ang;
    longint     cos_q;
    longint     sin_q;
    longint     z;
    longint     cos_sh;
    longint     sin_sh;
    longint     rot_x;
    longint     rot_y;
    logic [32:0] sx;
    logic [32:0] sy;
    logic [32:0] sh;
    bit         flip;
    ppc_out_t   r;

    ang = longint'(t.pose_heading) * (64'sd1 <<< ANG_SHIFT);
    ang = ang % ANGLE_TWO_PI;
    if (ang < 0) ang += ANGLE_TWO_PI;
    if (ang >= ANGLE_PI) ang -= ANGLE_TWO_PI;
    flip = 1'b0;
    if (ang > ANGLE_HALF_PI) begin
      ang -= ANGLE_PI;
      flip = 1'b1;
    end else if (ang < -ANGLE_HALF_PI) begin
      ang += ANGLE_PI;
      flip = 1'b1;
    end

    cos_q = START_GAIN;
    sin_q = 0;
    z     = ang;
    for (int k = 0; k < CORDIC_STAGES; k++) begin
      cos_sh = cos_q >>> k;
      sin_sh = sin_q >>> k;
      if (z >= 0) begin
        cos_q -= sin_sh;
        sin_q += cos_sh;
        z     -= ARCTAN_Q30[k];
      end else begin
        cos_q += sin_sh;
        sin_q -= cos_sh;
        z     += ARCTAN_Q30[k];
      end
    end
    if (flip) begin
      cos_q = -cos_q;
      sin_q = -sin_q;
    end

    if (t.opcode == OP_TRANSPOSED) begin
      rot_x = round_q30(longint'(t.step_x) * cos_q + longint'(t.step_y) * sin_q);
      rot_y = round_q30(longint'(t.step_y) * cos_q - longint'(t.step_x) * sin_q);
    end else begin
      rot_x = round_q30(longint'(t.step_x) * cos_q - longint'(t.step_y) * sin_q);
      rot_y = round_q30(longint'(t.step_x) * sin_q + longint'(t.step_y) * cos_q);
    end

    sx = clamp_coord(longint'(t.pose_x) + rot_x);
    sy = clamp_coord(longint'(t.pose_y) + rot_y);
    sh = clamp_coord(longint'(t.pose_heading) + longint'(t.step_heading));
    r.new_x       = sx[31:0];
    r.new_y       = sy[31:0];
    r.new_heading = sh[31:0];
    r.saturated   = sx[32] | sy[32] | sh[32];
    return r;
  endfunction

  function automatic int field_differs(input string name, input longint want,
                                       input longint got);
    if (want == got) return 0;
    $display("%0t %s expected %0d got %0d", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_i) begin
      expected_poses.push_back(compose_pose(in_data_i));
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (expected_poses.size() == 0) begin
        $display("%0t unexpected transfer: expected none got %h", $time, out_data_i);
        mismatch_cnt++;
      end else begin
        oldest_pose = expected_poses.pop_front();
        mismatch_cnt += field_differs("new_x", oldest_pose.new_x, out_data_i.new_x);
        mismatch_cnt += field_differs("new_y", oldest_pose.new_y, out_data_i.new_y);
        mismatch_cnt += field_differs("new_heading", oldest_pose.new_heading,
                                      out_data_i.new_heading);
        mismatch_cnt += field_differs("saturated", oldest_pose.saturated,
                                      out_data_i.saturated);
      end
    end
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top for planar_pose_compounding: sends directed and random pose
// transfers with random gaps and output stalls, then reports the verdict.
// Depends on ppc_pkg, the block and ppc_pose_checker.
`timescale 1ns / 1ps

module tb;
  import ppc_pkg::*;

  localparam int RANDOM_POSES = 1650;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  ppc_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  ppc_out_t out_data_o;
  int       pending_poses;
  int       mismatches;
  bit       steady;

  planar_pose_compounding u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  ppc_pose_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_data_i      (out_data_o),
    .pending_poses_o (pending_poses),
    .mismatches_o    (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("planar_pose_compounding: mismatch");
    $finish;
  end

  function automatic logic [31:0] random_coord();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1, 2: v = 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      default: v = ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                   ^ 32'($urandom_range(0, 32'h0000_FFFF));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] random_heading();
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1, 2: v = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      default: v = 32'(($signed($urandom_range(0, 16)) - 8) * 102944
                       + $signed($urandom_range(0, 8)) - 4);
    endcase
    return v;
  endfunction

  task automatic send_pose(input ppc_in_t p);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_both_ops(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] ph, input logic [31:0] sx,
                               input logic [31:0] sy, input logic [31:0] sh);
    ppc_in_t p;
    p.pose_x       = px;
    p.pose_y       = py;
    p.pose_heading = ph;
    p.step_x       = sx;
    p.step_y       = sy;
    p.step_heading = sh;
    for (int k = 0; k < 2; k++) begin
      p.opcode = k[0];
      send_pose(p);
    end
  endtask

  initial begin
    int stall;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_stall_i <= 1'b1;
        repeat (stall) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  initial begin
    ppc_in_t p;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    steady     = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // angle reduction boundaries around 0, pi/2, pi and 2*pi, then saturation
    send_both_ops(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_both_ops(32'h0001_0000, -32'sh0002_0000, 32'h0, 32'h0003_0000,
                  32'h0001_8000, 32'h0000_8000);
    send_both_ops(32'h0, 32'h0, 32'd205887, 32'h0001_0000, 32'h0001_0000, 32'h0);
    send_both_ops(32'h0, 32'h0, 32'd205888, 32'h0001_0000, 32'h0001_0000, 32'h0);
    send_both_ops(32'h0, 32'h0, 32'd102943, 32'h0001_0000, 32'h0002_0000, 32'h0);
    send_both_ops(32'h0, 32'h0, 32'd102944, 32'h0001_0000, 32'h0002_0000, 32'h0);
    send_both_ops(32'h0, 32'h0, -32'sd102944, 32'h0002_0000, 32'h0001_0000, 32'h0);
    send_both_ops(32'h0, 32'h0, -32'sd205888, 32'h0002_0000, 32'h0001_0000, 32'h0);
    send_both_ops(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h0000_0001);
    send_both_ops(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000, 32'hFFFF_FFFF);
    send_both_ops(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_both_ops(32'h0, 32'h0, -32'sd411775, 32'h8000_0000, 32'h8000_0000,
                  32'h8000_0000);

    for (int n = 0; n < RANDOM_POSES; n++) begin
      steady = (n % 300) < 60;
      if (n == RANDOM_POSES / 2) begin
        // drain the pipeline before resuming
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_poses != 0);
      end
      p.opcode       = 1'($urandom_range(0, 1));
      p.pose_x       = random_coord();
      p.pose_y       = random_coord();
      p.pose_heading = random_heading();
      p.step_x       = random_coord();
      p.step_y       = random_coord();
      p.step_heading = random_heading();
      send_pose(p);
    end
    in_valid_i <= 1'b0;

    while (pending_poses != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("planar_pose_compounding: match");
    end else begin
      $display("planar_pose_compounding: mismatch");
    end
    $finish;
  end

endmodule
